// ===== src/mav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average package
// Shared types and fixed constants for the moving average window block.
// ----------------------------------------------------------------------------
package mav_pkg;

	// The window length register is five bits wide on the configuration port.
	localparam int CFG_BITS = 5;

	// Window length after reset, before it is clamped to the number of taps.
	localparam int WINDOW_RESET = 4;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_UPDATE = 4'b0010,
		ST_DIVIDE = 4'b0100,
		ST_DONE   = 4'b1000
	} mav_state_t;

	// Status of the iterative divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== src/mav_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read and one write per cycle at a single address, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module mav_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wr_data,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[addr];
		end
	end

endmodule

// ===== src/mav_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring radix-2 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mav_divider #(
	parameter int DIVIDEND_BITS = 20,
	parameter int DIVISOR_BITS  = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic [DIVIDEND_BITS-1:0] quotient,
	output mav_pkg::div_status_t     status
);

	localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

	logic [CNT_W-1:0]         cnt_q;
	logic                     done_q;
	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  div_q;
	logic [DIVISOR_BITS:0]    shifted;
	logic                     fits;

	// The remainder stays below the divisor, so one extra bit holds the shifted value.
	assign shifted = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIVIDEND_BITS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
			if (fits) begin
				rem_q <= DIVISOR_BITS'(shifted - {1'b0, div_q});
			end else begin
				rem_q <= DIVISOR_BITS'(shifted);
			end
		end
	end

	assign quotient    = quo_q;
	assign status.busy = cnt_q != '0;
	assign status.done = done_q;

endmodule

// ===== src/moving_average_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average window
// Running-sum moving average over the last window_length signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the in_valid / in_ready channel; each accepted transaction
//   yields exactly one result transaction on out_valid / out_ready carrying the
//   average and the window_full flag.
//   The average is the running sum divided by the number of samples seen since
//   the last clear, capped at the window length, truncated toward zero.
//   An accepted sample passes through the update, divide and done states
//   before its result is loaded into the output register. The divide state
//   waits for the radix-2 divider, which produces one quotient bit of the
//   running sum per cycle. A new sample is accepted once the previous result
//   sits in the output register, so a sample is never taken before the last
//   one is through.
//   If the receiver stalls, the result holds in the output register; the next
//   sample can still be processed, but its result waits until the output
//   register is free.
//   Reset sets the window length to 4 (or MAX_TAPS if smaller) and empties the
//   window. Writing window_length clamps it to 1..MAX_TAPS and also empties
//   the window; write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module moving_average_window #(
	parameter int MAX_TAPS    = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          window_length_we,
	input  logic [mav_pkg::CFG_BITS-1:0]  window_length,
	// Sample channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic                          window_full
);

	// Widths that follow from the parameters.
	localparam int SLOT_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int WIN_W    = $clog2(MAX_TAPS + 1);
	localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_TAPS);
	localparam int WIN_RST  = (mav_pkg::WINDOW_RESET < MAX_TAPS) ?
		mav_pkg::WINDOW_RESET : MAX_TAPS;

	mav_pkg::mav_state_t state_q;

	logic [WIN_W-1:0]              win_q;     // clamped window length
	logic [SLOT_W-1:0]             slot_q;    // next ring slot to overwrite
	logic [WIN_W-1:0]              fill_q;    // samples held, saturates at win_q
	logic signed [SUM_BITS-1:0]    total_q;   // sum of the samples in the window
	logic signed [SAMPLE_BITS-1:0] sample_q;  // sample being processed
	logic                          neg_q;     // sign of the sum being divided
	logic                          full_q;    // window_full for the pending result

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] average_q;
	logic                          window_full_q;

	logic                          in_fire;
	logic                          out_free;

	// Ring buffer signals.
	logic                          ram_rd_en;
	logic                          ram_wr_en;
	logic [SAMPLE_BITS-1:0]        ram_rd_data;

	// Update arithmetic.
	logic signed [SUM_BITS-1:0]    old_ext;
	logic signed [SUM_BITS-1:0]    total_next;
	logic [WIN_W-1:0]              fill_next;
	logic [WIN_W-1:0]              slot_inc;
	logic [SUM_BITS-1:0]           total_mag;

	// Divider signals.
	logic                          div_start;
	logic [SUM_BITS-1:0]           quotient;
	mav_pkg::div_status_t          div_status;
	logic [SUM_BITS-1:0]           quo_signed;

	assign in_ready = (state_q == mav_pkg::ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// The output register may be loaded when empty or when its content leaves now.
	assign out_free = !out_valid_q || out_ready;

	// The ring is read at the write slot when a sample is accepted and written
	// with the new sample in the next cycle, in the update state, once the oldest entry is known.
	assign ram_rd_en = in_fire;
	assign ram_wr_en = (state_q == mav_pkg::ST_UPDATE);

	mav_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_TAPS)
	) u_ring (
		.clk     (clk),
		.rd_en   (ram_rd_en),
		.wr_en   (ram_wr_en),
		.addr    (slot_q),
		.wr_data (sample_q),
		.rd_data (ram_rd_data)
	);

	// Until the window has filled once, the slot being overwritten has never
	// been written since the last clear and contributes zero to the sum. The
	// fill count therefore stands in for clearing the ring.
	always_comb begin
		if (fill_q == win_q) begin
			old_ext = SUM_BITS'($signed(ram_rd_data));
		end else begin
			old_ext = '0;
		end
		total_next = total_q - old_ext + SUM_BITS'(sample_q);
		fill_next  = (fill_q < win_q) ? fill_q + 1'b1 : fill_q;
		slot_inc   = WIN_W'(slot_q) + 1'b1;
		total_mag  = total_next[SUM_BITS-1] ? (~total_next + 1'b1) : total_next;
	end

	assign div_start = (state_q == mav_pkg::ST_UPDATE);

	mav_divider #(
		.DIVIDEND_BITS (SUM_BITS),
		.DIVISOR_BITS  (WIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_mag),
		.divisor  (fill_next),
		.quotient (quotient),
		.status   (div_status)
	);

	// Truncation toward zero: divide the magnitude, then restore the sign.
	assign quo_signed = neg_q ? (~quotient + 1'b1) : quotient;

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mav_pkg::ST_IDLE;
			win_q       <= WIN_W'(WIN_RST);
			slot_q      <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register fills from the sequencer and empties when its
			// transaction is taken.
			if ((state_q == mav_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (window_length_we) begin
				if (window_length == '0) begin
					win_q <= WIN_W'(1);
				end else if (int'(window_length) > MAX_TAPS) begin
					win_q <= WIN_W'(MAX_TAPS);
				end else begin
					win_q <= WIN_W'(window_length);
				end
				slot_q  <= '0;
				fill_q  <= '0;
				total_q <= '0;
			end

			unique case (state_q)
				mav_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= mav_pkg::ST_UPDATE;
					end
				end
				mav_pkg::ST_UPDATE: begin
					total_q <= total_next;
					fill_q  <= fill_next;
					slot_q  <= (slot_inc == win_q) ? '0 : SLOT_W'(slot_inc);
					state_q <= mav_pkg::ST_DIVIDE;
				end
				mav_pkg::ST_DIVIDE: begin
					if (div_status.done) begin
						state_q <= mav_pkg::ST_DONE;
					end
				end
				mav_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= mav_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mav_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= sample;
		end
		if (state_q == mav_pkg::ST_UPDATE) begin
			neg_q  <= total_next[SUM_BITS-1];
			full_q <= (fill_next == win_q);
		end
		if ((state_q == mav_pkg::ST_DONE) && out_free) begin
			average_q     <= SAMPLE_BITS'(quo_signed);
			window_full_q <= full_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign average     = average_q;
	assign window_full = window_full_q;

endmodule

// ===== sim/tb_moving_average_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average window testbench
// Drives signed samples into the block with random bursts and gaps while the
// result side stalls on its own pattern. A behavioral running-sum predictor
// computes each expected average and full flag, and every result transaction
// is compared field by field in order. Directed tests cover the reset window,
// full-scale samples, truncation toward zero and clamped length writes. Random
// phases then rewrite the window length and stream mixed samples.
// ----------------------------------------------------------------------------
module tb_moving_average_window;

	localparam int MAX_TAPS    = 16;
	localparam int SAMPLE_BITS = 16;
	// The divider yields one bit of the running sum per cycle and the sequencer adds
	// its own states; this covers the wait from acceptance to a valid result.
	localparam int LATENCY     = SAMPLE_BITS + $clog2(MAX_TAPS) + 4;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int RANDOM_PHASES   = 10;

	localparam logic signed [SAMPLE_BITS-1:0] MAX_SAMPLE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// How random samples are drawn in one phase.
	typedef enum logic {
		PROFILE_MIXED,
		PROFILE_FULL_SCALE
	} sample_profile_t;

	// One expected result transaction.
	typedef struct {
		logic signed [SAMPLE_BITS-1:0] average;
		logic                          window_full;
	} average_result_t;

	// Block ports. Every input holds a known value from time zero.
	logic                          clk              = 1'b0;
	logic                          arst_n           = 1'b0;
	logic                          window_length_we = 1'b0;
	logic [mav_pkg::CFG_BITS-1:0]  window_length    = '0;
	logic                          in_valid         = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample           = '0;
	logic                          out_valid;
	logic                          out_ready        = 1'b0;
	logic signed [SAMPLE_BITS-1:0] average;
	logic                          window_full;

	// Predictor state: the sample history, the slot the next sample goes to,
	// the exact sum of the window and how many samples it currently holds.
	logic signed [SAMPLE_BITS-1:0] tap_history [MAX_TAPS];
	int                            next_tap;
	int                            sum_of_taps;
	int                            taps_filled;
	int                            window_taps;

	// Averages still owed by the block, oldest first.
	average_result_t pending_averages [$];

	// Sender pacing: the valid line is held across back-to-back transactions
	// inside a burst and dropped only for a gap.
	bit valid_held;
	int burst_left;

	// Receiver stall pattern, rotated every cycle and reloaded now and then.
	logic [11:0] ready_pattern = '1;
	int          ready_cycles;

	int samples_sent;
	int averages_checked;
	int settings_used;
	int errors;

	moving_average_window #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.window_length_we(window_length_we),
		.window_length   (window_length),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.average         (average),
		.window_full     (window_full)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Empties the predicted window. Both reset and every length write do this.
	function automatic void clear_window_model();
		foreach (tap_history[i]) tap_history[i] = '0;
		next_tap    = 0;
		sum_of_taps = 0;
		taps_filled = 0;
	endfunction

	// Pushes one sample through the predicted window and returns the result
	// that the block must produce for it. The oldest entry at the write slot
	// leaves the sum before the new sample enters, and the divisor is the fill
	// count, so the startup averages are the true mean of what was seen.
	// SystemVerilog integer division truncates toward zero as required.
	function automatic average_result_t predict_average(input logic signed [SAMPLE_BITS-1:0] x);
		average_result_t r;
		sum_of_taps = sum_of_taps - int'(tap_history[next_tap]) + int'(x);
		tap_history[next_tap] = x;
		next_tap = (next_tap + 1) % window_taps;
		if (taps_filled < window_taps) begin
			taps_filled++;
		end
		r.average     = SAMPLE_BITS'(sum_of_taps / taps_filled);
		r.window_full = (taps_filled == window_taps);
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			return pick[0] ? MAX_SAMPLE : MIN_SAMPLE;
		end else if (pick < 22) begin
			// Small values make truncation toward zero visible.
			return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
		end
		return SAMPLE_BITS'($urandom);
	endfunction

	// Offers one sample and waits for its transaction. The expectation is
	// recorded at the accepting edge. At the end of a burst the valid line is
	// dropped for a random gap; inside a burst it stays high so that the next
	// sample follows immediately.
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
		int gap;
		sample     <= x;
		in_valid   <= 1'b1;
		valid_held = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_averages.push_back(predict_average(x));
		samples_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			// Mostly short bursts, sometimes a long stretch with no gaps.
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid   <= 1'b0;
				valid_held = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops offering samples and waits until every owed result has arrived.
	task automatic drain_results();
		if (valid_held) begin
			in_valid   <= 1'b0;
			valid_held = 1'b0;
		end
		while (pending_averages.size() != 0) @(posedge clk);
	endtask

	// Writes the window length while the block is idle. The block clamps the
	// value to 1..MAX_TAPS and clears its window; the predictor does the same.
	task automatic write_window_length(input int unsigned value);
		drain_results();
		repeat (LATENCY) @(posedge clk);
		window_length_we <= 1'b1;
		window_length    <= mav_pkg::CFG_BITS'(value);
		@(posedge clk);
		window_length_we <= 1'b0;
		if (value < 1) begin
			window_taps = 1;
		end else if (value > MAX_TAPS) begin
			window_taps = MAX_TAPS;
		end else begin
			window_taps = value;
		end
		clear_window_model();
		settings_used++;
	endtask

	// The reset length is used as is: full-scale samples, then a fall to the
	// negative limit, then a small value that leaves a negative fraction.
	task automatic test_reset_window();
		send_sample(MAX_SAMPLE);
		send_sample(MAX_SAMPLE);
		send_sample(MIN_SAMPLE);
		send_sample(MIN_SAMPLE);
		send_sample(SAMPLE_BITS'(-1));
		drain_results();
	endtask

	// A written length of zero becomes one, so every average is the sample.
	task automatic test_length_zero_clamps_to_one();
		write_window_length(0);
		send_sample(MIN_SAMPLE);
		send_sample(MAX_SAMPLE);
		send_sample(SAMPLE_BITS'(-3));
		drain_results();
	endtask

	// The largest register value is clamped to the number of taps.
	task automatic test_length_above_max_clamps();
		write_window_length((1 << mav_pkg::CFG_BITS) - 1);
		send_sample(SAMPLE_BITS'(1));
		send_sample(SAMPLE_BITS'(-2));
		send_sample(SAMPLE_BITS'(3));
		send_sample(MIN_SAMPLE);
		drain_results();
	endtask

	// A two-tap window with alternating bit patterns in the samples, so the
	// oldest entry leaves the sum from the third transaction on.
	task automatic test_two_tap_window();
		write_window_length(2);
		send_sample(SAMPLE_BITS'(16'h5555));
		send_sample(SAMPLE_BITS'(16'hAAAA));
		send_sample(SAMPLE_BITS'(0));
		send_sample(SAMPLE_BITS'(-7));
		drain_results();
	endtask

	// Random phases, each with its own length write. The first phase holds
	// long runs at each full-scale limit in the widest window, which drives
	// the running sum to both of its extremes; the others mix random samples.
	task automatic test_random_windows();
		int unsigned     phase_lengths [RANDOM_PHASES];
		sample_profile_t profile;
		phase_lengths = '{MAX_TAPS, 1, (1 << mav_pkg::CFG_BITS) - 1, 0, MAX_TAPS + 1,
			0, 0, 0, 0, 0};
		for (int p = 5; p < RANDOM_PHASES; p++) begin
			phase_lengths[p] = $urandom_range(0, (1 << mav_pkg::CFG_BITS) - 1);
		end
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			profile = (p == 0) ? PROFILE_FULL_SCALE : PROFILE_MIXED;
			write_window_length(phase_lengths[p]);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (profile == PROFILE_FULL_SCALE && $urandom_range(0, 7) != 0) begin
					send_sample(((i / 20) % 2) ? MIN_SAMPLE : MAX_SAMPLE);
				end else begin
					send_sample(random_sample());
				end
			end
		end
		drain_results();
	endtask

	// Receiver: ready follows a rotating pattern. The patterns drawn range
	// from always ready through mostly stalled.
	always @(posedge clk) begin
		ready_cycles++;
		if (ready_cycles % 64 == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pattern = '1;
				1: ready_pattern = 12'($urandom);
				2: ready_pattern = 12'($urandom | $urandom);
				default: ready_pattern = 12'($urandom & $urandom);
			endcase
		end
		out_ready     <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[11:1]};
	end

	// Result checker: each result transaction is matched against the oldest
	// expectation, field by field.
	always @(posedge clk) begin : check_averages
		average_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_averages.size() == 0) begin
				$display("%0t: unexpected result, average %0d, window_full %0b",
					$time, average, window_full);
				errors++;
			end else begin
				want = pending_averages.pop_front();
				averages_checked++;
				if (average !== want.average) begin
					$display("%0t: average mismatch, expected %0d, actual %0d",
						$time, want.average, average);
					errors++;
				end
				if (window_full !== want.window_full) begin
					$display("%0t: window_full mismatch, expected %0b, actual %0b",
						$time, want.window_full, window_full);
					errors++;
				end
			end
		end
	end

	initial begin
		valid_held  = 1'b0;
		burst_left  = 1;
		window_taps = (mav_pkg::WINDOW_RESET > MAX_TAPS) ? MAX_TAPS : mav_pkg::WINDOW_RESET;
		clear_window_model();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_length_zero_clamps_to_one();
		test_length_above_max_clamps();
		test_two_tap_window();
		test_random_windows();

		// Any result beyond the last expected one would show up in this window.
		drain_results();
		repeat (2 * LATENCY) @(posedge clk);
		errors += pending_averages.size();

		$display("Checked %0d averages for %0d samples across %0d window length writes,",
			averages_checked, samples_sent, settings_used);
		$display("including clamped writes at both ends and full-scale sums in the widest window.");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#1_000_000;
		$display("Timeout with %0d results outstanding.", pending_averages.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
